FILE: hdl/hbcp_pkg.sv
// Shared types, color codes and the dot color decode for the hi-res
// byte to color pixel converter. No dependencies.
`default_nettype none

package hbcp_pkg;

    typedef logic [2:0] color_t;

    localparam color_t COLOR_BLACK  = 3'd0;
    localparam color_t COLOR_WHITE  = 3'd1;
    localparam color_t COLOR_PURPLE = 3'd2;
    localparam color_t COLOR_GREEN  = 3'd3;
    localparam color_t COLOR_BLUE   = 3'd4;
    localparam color_t COLOR_ORANGE = 3'd5;

    localparam int DOTS_PER_BYTE = 7;
    localparam int QUEUE_DEPTH   = 2;

    // One accepted byte, classified: all dot colors plus the emission layout.
    typedef struct packed {
        color_t                          held_color;
        color_t                          rep_color;
        logic [DOTS_PER_BYTE-1:0][2:0]   dot_colors;
        logic [1:0]                      n_held;
        logic [1:0]                      base;
        logic [3:0]                      last_idx;
        logic                            line_last;
    } beat_desc_t;

    function automatic color_t dot_color(
        input logic mode,
        input logic prev,
        input logic own,
        input logic next,
        input logic shift,
        input logic parity
    );
        logic [2:0] row;
        logic [1:0] col;
        color_t     c;
        row = {prev, own, next};
        col = {shift, parity};
        c   = COLOR_BLACK;
        if (!mode) begin
            c = own ? COLOR_WHITE : COLOR_BLACK;
        end
        else begin
            unique case (row) inside
                3'd0, 3'd1, 3'd4: c = COLOR_BLACK;
                3'd3, 3'd6, 3'd7: c = COLOR_WHITE;
                3'd2: begin
                    unique case (col)
                        2'd0:    c = COLOR_PURPLE;
                        2'd1:    c = COLOR_GREEN;
                        2'd2:    c = COLOR_BLUE;
                        default: c = COLOR_ORANGE;
                    endcase
                end
                default: begin
                    unique case (col)
                        2'd0:    c = COLOR_GREEN;
                        2'd1:    c = COLOR_PURPLE;
                        2'd2:    c = COLOR_ORANGE;
                        default: c = COLOR_BLUE;
                    endcase
                end
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hbcp_front.sv
// Front end: accepts video bytes, tracks the held dot across bytes and
// builds one beat descriptor per byte. Depends on hbcp_pkg.
`default_nettype none

module hbcp_front
    import hbcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] video_byte,
    input  wire logic       last_in_line,
    input  wire logic       queue_full,
    output logic            push,
    output beat_desc_t      push_data
);

    logic color_mode_reg;
    logic held_dot_reg,      held_dot_next;
    logic held_prev_dot_reg, held_prev_dot_next;
    logic held_shift_reg,    held_shift_next;
    logic held_valid_reg,    held_valid_next;
    logic parity_reg,        parity_next;

    logic       sh;
    logic [1:0] n_held;
    logic [1:0] n_end;
    logic [4:0] n_total;
    color_t     held_color;

    assign in_stall = queue_full;
    assign push     = in_valid && !in_stall;
    assign sh       = video_byte[7];

    always_comb
    begin
        logic prev;
        prev       = held_valid_reg ? held_dot_reg : 1'b0;
        held_color = dot_color(color_mode_reg, held_prev_dot_reg, held_dot_reg,
                               video_byte[0], held_shift_reg, ~parity_reg);
        for (int k = 0; k < DOTS_PER_BYTE - 1; k++) begin
            push_data.dot_colors[k] = dot_color(color_mode_reg, prev, video_byte[k],
                                                video_byte[k+1], sh,
                                                parity_reg ^ k[0]);
            prev = video_byte[k];
        end
        push_data.dot_colors[DOTS_PER_BYTE-1] =
            dot_color(color_mode_reg, video_byte[5], video_byte[6], 1'b0, sh, parity_reg);

        n_held  = held_valid_reg ? (held_shift_reg ? 2'd1 : 2'd2) : 2'd0;
        n_end   = last_in_line ? (sh ? 2'd1 : 2'd2) : 2'd0;
        n_total = 5'd12 + {3'd0, n_held} + {4'd0, sh} + {3'd0, n_end};

        push_data.held_color = held_color;
        push_data.rep_color  = held_valid_reg ? held_color : COLOR_BLACK;
        push_data.n_held     = n_held;
        push_data.base       = n_held + {1'b0, sh};
        push_data.last_idx   = 4'(n_total - 5'd1);
        push_data.line_last  = last_in_line;

        held_dot_next      = held_dot_reg;
        held_prev_dot_next = held_prev_dot_reg;
        held_shift_next    = held_shift_reg;
        held_valid_next    = held_valid_reg;
        parity_next        = parity_reg;
        if (push) begin
            if (last_in_line) begin
                held_dot_next      = 1'b0;
                held_prev_dot_next = 1'b0;
                held_shift_next    = 1'b0;
                held_valid_next    = 1'b0;
                parity_next        = 1'b0;
            end
            else begin
                held_dot_next      = video_byte[6];
                held_prev_dot_next = video_byte[5];
                held_shift_next    = sh;
                held_valid_next    = 1'b1;
                parity_next        = ~parity_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            color_mode_reg    <= 1'b1;
            held_dot_reg      <= 1'b0;
            held_prev_dot_reg <= 1'b0;
            held_shift_reg    <= 1'b0;
            held_valid_reg    <= 1'b0;
            parity_reg        <= 1'b0;
        end
        else begin
            if (cfg_wr_en) begin
                color_mode_reg <= cfg_wr_data;
            end
            held_dot_reg      <= held_dot_next;
            held_prev_dot_reg <= held_prev_dot_next;
            held_shift_reg    <= held_shift_next;
            held_valid_reg    <= held_valid_next;
            parity_reg        <= parity_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hbcp_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on hbcp_pkg.
`default_nettype none

module hbcp_queue
    import hbcp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  beat_desc_t  push_data,
    input  wire logic   pop,
    output beat_desc_t  pop_data,
    output logic        not_empty,
    output logic        full
);

    beat_desc_t entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: hdl/hbcp_back.sv
// Back end: walks one descriptor per byte and emits one half-pixel beat
// per cycle when not stalled, via an output register. Needs hbcp_pkg.
`default_nettype none

module hbcp_back
    import hbcp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  beat_desc_t  desc,
    input  wire logic   desc_valid,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [2:0]  half_pixel_color,
    output logic        last_of_run,
    output logic        line_end
);

    logic [3:0] idx_reg,       idx_next;
    logic       out_valid_reg, out_valid_next;
    color_t     color_reg,     color_next;
    logic       run_last_reg,  run_last_next;
    logic       line_end_reg,  line_end_next;

    logic       load;
    logic       at_last;
    logic [3:0] dot_pos;

    assign out_valid        = out_valid_reg;
    assign half_pixel_color = color_reg;
    assign last_of_run      = run_last_reg;
    assign line_end         = line_end_reg;

    assign load    = desc_valid && (!out_valid_reg || !out_stall);
    assign at_last = (idx_reg == desc.last_idx);
    assign pop     = load && at_last;
    assign dot_pos = idx_reg - {2'd0, desc.base};

    always_comb
    begin
        if (idx_reg < {2'd0, desc.n_held}) begin
            color_next = desc.held_color;
        end
        else if (idx_reg < {2'd0, desc.base}) begin
            color_next = desc.rep_color;
        end
        else if (dot_pos < 4'd12) begin
            color_next = desc.dot_colors[dot_pos[3:1]];
        end
        else begin
            color_next = desc.dot_colors[DOTS_PER_BYTE-1];
        end
        run_last_next = at_last;
        line_end_next = at_last && desc.line_last;

        idx_next = idx_reg;
        if (load) begin
            idx_next = at_last ? 4'd0 : idx_reg + 4'd1;
        end

        if (load) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            color_reg    <= color_next;
            run_last_reg <= run_last_next;
            line_end_reg <= line_end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> idx_reg <= desc.last_idx)
        else $error("half-pixel index past end of run");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 4'd0)
        else $error("index not cleared after run");

    a_line_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_end) |-> last_of_run)
        else $error("line end without end of run");

endmodule

`default_nettype wire

FILE: hdl/hires_byte_to_color_pixels.sv
// Top level of the hi-res byte to color pixel converter.
// Depends on hbcp_pkg, hbcp_front, hbcp_queue, hbcp_back.
//
// Usage:
//   Input beats carry one screen byte (video_byte) and last_in_line; a beat
//   is taken when in_valid is high and in_stall low. Output beats carry one
//   half-pixel color code with last_of_run and line_end flags; a beat is taken
//   when out_valid is high and out_stall low.
//   Each byte yields 12 to 16 half-pixels: 14 in steady state with an
//   unchanged shift bit, 2 fewer at line start, plus the last dot at line end.
//   The first half-pixel of a byte passes through a queue entry and then
//   the output register, if the back end is free.
//   Throughput: one half-pixel per cycle while out_stall is low, set by the
//   single output register. Two bytes of classified work can queue ahead
//   of the output.
//   color_mode (cfg_wr_en / cfg_wr_data) selects artifact color (1) or black
//   and white (0); write it only while the block is idle.
//   Reset: output empty, queue empty, no dot held, color mode on.
//   A stalled output holds its beat; the queue then fills and in_stall rises.
`default_nettype none

module hires_byte_to_color_pixels
    import hbcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] video_byte,
    input  wire logic       last_in_line,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      half_pixel_color,
    output logic            last_of_run,
    output logic            line_end
);

    beat_desc_t push_data;
    beat_desc_t pop_data;
    logic       push;
    logic       pop;
    logic       not_empty;
    logic       full;

    hbcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .video_byte   (video_byte),
        .last_in_line (last_in_line),
        .queue_full   (full),
        .push         (push),
        .push_data    (push_data)
    );

    hbcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty),
        .full      (full)
    );

    hbcp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .desc             (pop_data),
        .desc_valid       (not_empty),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .half_pixel_color (half_pixel_color),
        .last_of_run      (last_of_run),
        .line_end         (line_end)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for hires_byte_to_color_pixels: drives screen bytes,
// predicts the half-pixel stream and compares it beat by beat.
// Depends on hbcp_pkg and the hires_byte_to_color_pixels RTL.
`timescale 1ns / 100ps

module tb;
    import hbcp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [7:0] vb;
        logic       eol;
    } screen_beat_t;

    typedef struct packed {
        color_t color;
        logic   run_last;
        logic   line_last;
    } half_pixel_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_wr_en    = 1'b0;
    logic       cfg_wr_data  = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] video_byte   = 8'h00;
    logic       last_in_line = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [2:0] half_pixel_color;
    logic       last_of_run;
    logic       line_end;

    screen_beat_t byte_q[$];
    half_pixel_t  pixel_q[$];

    int  bytes_sent   = 0;
    int  bytes_taken  = 0;
    int  fail_count   = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0;
    int  stall_pct    = 0;
    logic hold_on     = 1'b0;
    int  hold_count   = 0;
    logic in_beat     = 1'b0;

    // predictor state
    logic   mode_now    = 1'b1;
    logic   held_dot    = 1'b0;
    logic   held_prev   = 1'b0;
    logic   held_shift  = 1'b0;
    logic   held_valid  = 1'b0;
    logic   col_par     = 1'b0;
    color_t last_color  = COLOR_BLACK;

    hires_byte_to_color_pixels i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .video_byte       (video_byte),
        .last_in_line     (last_in_line),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .half_pixel_color (half_pixel_color),
        .last_of_run      (last_of_run),
        .line_end         (line_end)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic color_t dot_hue(logic prev, logic own, logic nxt,
                                       logic shift, logic parity);
        logic odd;
        if (!mode_now)
            return own ? COLOR_WHITE : COLOR_BLACK;
        if (own && (prev || nxt))
            return COLOR_WHITE;
        if (!own && !(prev && nxt))
            return COLOR_BLACK;
        // lone dot takes the column's hue, a one-dot gap the opposite one
        odd = own ? parity : ~parity;
        if (shift)
            return odd ? COLOR_ORANGE : COLOR_BLUE;
        return odd ? COLOR_GREEN : COLOR_PURPLE;
    endfunction

    task automatic decode_byte(input logic [7:0] vb, input logic eol);
        color_t      cols[$];
        color_t      c;
        half_pixel_t hp;
        logic        sh;
        logic        par;
        logic        prev;
        int          k;
        sh  = vb[7];
        par = col_par;
        if (held_valid)
        begin
            c = dot_hue(held_prev, held_dot, vb[0], held_shift, ~par);
            cols.push_back(c);
            if (!held_shift)
                cols.push_back(c);
            last_color = c;
        end
        if (sh)
            cols.push_back(last_color);
        prev = held_valid ? held_dot : 1'b0;
        for (k = 0; k < 6; k++)
        begin
            c = dot_hue(prev, vb[k], vb[k+1], sh, par ^ k[0]);
            cols.push_back(c);
            cols.push_back(c);
            last_color = c;
            prev = vb[k];
        end
        held_dot   = vb[6];
        held_prev  = vb[5];
        held_shift = sh;
        held_valid = 1'b1;
        col_par    = ~par;
        if (eol)
        begin
            c = dot_hue(held_prev, held_dot, 1'b0, sh, par);
            cols.push_back(c);
            if (!sh)
                cols.push_back(c);
            held_dot   = 1'b0;
            held_prev  = 1'b0;
            held_shift = 1'b0;
            held_valid = 1'b0;
            col_par    = 1'b0;
            last_color = COLOR_BLACK;
        end
        for (k = 0; k < cols.size(); k++)
        begin
            hp.color     = cols[k];
            hp.run_last  = (k == cols.size() - 1);
            hp.line_last = eol && (k == cols.size() - 1);
            pixel_q.push_back(hp);
        end
    endtask

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        half_pixel_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                mode_now = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected beat: expected none, %s %0d run %0b eol %0b",
                             $time, "got color", half_pixel_color, last_of_run,
                             line_end);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (half_pixel_color !== want.color || last_of_run !== want.run_last ||
                        line_end !== want.line_last)
                    begin
                        fail_count++;
                        $display("%0t: mismatch: expected color %0d run %0b eol %0b,",
                                 $time, want.color, want.run_last, want.line_last,
                                 " got color %0d run %0b eol %0b",
                                 half_pixel_color, last_of_run, line_end);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                decode_byte(video_byte, last_in_line);
                bytes_taken++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("hires_byte_to_color_pixels regression: fail");
                $finish;
            end
        end
        in_beat <= in_valid && !in_stall;
    end

    // byte driver
    always @(negedge clk)
    begin
        screen_beat_t nxt;
        if (rst_n && !(in_valid && !in_beat))
        begin
            if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = byte_q.pop_front();
                in_valid     <= 1'b1;
                video_byte   <= nxt.vb;
                last_in_line <= nxt.eol;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // pixel receiver
    always @(negedge clk)
    begin
        if (hold_on && hold_count < HOLD_CYCLES)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] vb, input logic eol);
        screen_beat_t b;
        b.vb  = vb;
        b.eol = eol;
        byte_q.push_back(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_taken != bytes_sent || pixel_q.size() != 0);
    endtask

    task automatic start_phase(input logic mode, input int idle_pct, input int stl_pct);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
    endtask

    // mostly whole scanlines of random bytes, some stray line marks
    task automatic send_random_lines(input int n_items);
        int   sent;
        int   len;
        int   i;
        logic eol;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            for (i = 0; i < len && sent < n_items; i++)
            begin
                eol = (i == len - 1);
                if ($urandom_range(0, 19) == 0)
                    eol = ~eol;
                send_byte(8'($urandom_range(0, 255)), eol);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        start_phase(1'b1, 0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h85, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(8'hD5, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h81, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC0, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h9C, 1'b0);
        send_byte(8'h63, 1'b0);

        // held dot from the line above is emitted in black and white
        start_phase(1'b0, 0, 0);
        send_random_lines(60);
        start_phase(1'b1, 46, 0);
        send_random_lines(70);
        start_phase(1'b1, 0, 46);
        send_random_lines(70);
        start_phase(1'b0, 20, 20);
        send_random_lines(60);

        // long output hold-off while bytes keep coming
        start_phase(1'b1, 0, 0);
        hold_on = 1'b1;
        send_random_lines(50);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("hires_byte_to_color_pixels regression: pass");
        else
            $display("hires_byte_to_color_pixels regression: fail");
        $finish;
    end

endmodule
